>>> sv/scaled_sprite_column_decoder_macros.svh
// ----------------------------------------------------------------------------
// Scaled sprite column decoder assertion macros
// Short forms for clocked implications with an async active-low reset.
// ----------------------------------------------------------------------------
`ifndef SCALED_SPRITE_COLUMN_DECODER_MACROS_SVH
`define SCALED_SPRITE_COLUMN_DECODER_MACROS_SVH

// same-cycle implication
`define SSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssc: same-cycle check failed");

// next-cycle implication
`define SSC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssc: next-cycle check failed");

`endif

>>> sv/ssc_pkg.sv
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types and constants of the scaled sprite column decoder.
// ----------------------------------------------------------------------------
package ssc_pkg;

  localparam int FRAC_BITS      = 16;
  localparam int MAX_OUT_HEIGHT = 4096;

  localparam int BYTE_W     = 8;
  localparam int ROW_W      = 12;
  localparam int STEP_W     = 24;
  localparam int HEIGHT_W   = 13;
  localparam int POS_INT_W  = 16;  // integer part of the source position
  localparam int ORCNT_W    = 16;  // saturating output row counter
  localparam int MAX_WRITES = 64;  // writes per data byte
  localparam int WCNT_W     = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  localparam logic [BYTE_W-1:0] END_MARK = 8'hff;

  // output word kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_MARK  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_STEP   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 1'b1;

  localparam logic [STEP_W-1:0]   RESET_ROW_STEP   = 24'd65536;
  localparam logic [HEIGHT_W-1:0] RESET_OUT_HEIGHT = 13'd200;

  typedef struct packed {
    logic [BYTE_W-1:0] column_byte;
    logic              column_start;
  } in_word_t;

  typedef struct packed {
    logic              kind;
    logic [ROW_W-1:0]  row;
    logic [BYTE_W-1:0] pixel;
    logic              last;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic load_byte;
    logic col_reset;
    logic load_len;
    logic clr_idx;
    logic load_top;
    logic step;
    logic clr_cnt;
    logic idx_inc;
    logic emit_pix;
    logic emit_mark;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic end_mark;
    logic len_zero;
    logic skip_need;
    logic hit;
    logic idx_done;
    logic out_free;
  } ctrl_status_t;

endpackage

>>> sv/ssc_ctrl.sv
// ----------------------------------------------------------------------------
// ssc_ctrl
// Sequencer: post parse phase and per-byte work states.
// ----------------------------------------------------------------------------
module ssc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  column_start_i,
  output logic                  in_stall_o,
  input  ssc_pkg::ctrl_status_t status_i,
  output ssc_pkg::ctrl_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SKIP,
    ST_EMIT,
    ST_MARK
  } state_e;

  typedef enum logic [2:0] {
    PH_TOP  = 3'd0,
    PH_LEN  = 3'd1,
    PH_PAD  = 3'd2,
    PH_DATA = 3'd3,
    PH_TAIL = 3'd4
  } phase_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    phase_d = phase_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_byte = 1'b1;
          if (column_start_i) begin
            cmd_o.col_reset = 1'b1;
            phase_d         = PH_TOP;
          end
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (phase_q)
          PH_LEN: begin
            cmd_o.load_len = 1'b1;
            phase_d        = PH_PAD;
            state_d        = ST_IDLE;
          end
          PH_PAD: begin
            cmd_o.clr_idx = 1'b1;
            phase_d       = status_i.len_zero ? PH_TAIL : PH_DATA;
            state_d       = ST_IDLE;
          end
          PH_DATA: begin
            cmd_o.clr_cnt = 1'b1;
            state_d       = ST_EMIT;
          end
          PH_TAIL: begin
            phase_d = PH_TOP;
            state_d = ST_IDLE;
          end
          default: begin
            if (status_i.end_mark) begin
              cmd_o.col_reset = 1'b1;
              phase_d         = PH_TOP;
              state_d         = ST_MARK;
            end else begin
              cmd_o.load_top = 1'b1;
              state_d        = ST_SKIP;
            end
          end
        endcase
      end
      ST_SKIP: begin
        if (status_i.skip_need) begin
          cmd_o.step = 1'b1;
        end else begin
          phase_d = PH_LEN;
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (status_i.hit) begin
          if (status_i.out_free) begin
            cmd_o.emit_pix = 1'b1;
            cmd_o.step     = 1'b1;
          end
        end else begin
          cmd_o.idx_inc = 1'b1;
          phase_d       = status_i.idx_done ? PH_TAIL : PH_DATA;
          state_d       = ST_IDLE;
        end
      end
      ST_MARK: begin
        if (status_i.out_free) begin
          cmd_o.emit_mark = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_TOP;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

>>> sv/ssc_datapath.sv
// ----------------------------------------------------------------------------
// ssc_datapath
// Position stepper, post registers, config registers and output register.
// ----------------------------------------------------------------------------
module ssc_datapath #(
  parameter int FRAC_BITS      = ssc_pkg::FRAC_BITS,
  parameter int MAX_OUT_HEIGHT = ssc_pkg::MAX_OUT_HEIGHT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [ssc_pkg::BYTE_W-1:0]           column_byte_i,
  input  logic                                 cfg_we_i,
  input  logic [ssc_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [ssc_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  ssc_pkg::ctrl_cmd_t                   cmd_i,
  output ssc_pkg::ctrl_status_t                status_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output ssc_pkg::out_word_t                   out_word_o
);

  localparam int BYTE_W    = ssc_pkg::BYTE_W;
  localparam int STEP_W    = ssc_pkg::STEP_W;
  localparam int HEIGHT_W  = ssc_pkg::HEIGHT_W;
  localparam int POS_INT_W = ssc_pkg::POS_INT_W;
  localparam int ORCNT_W   = ssc_pkg::ORCNT_W;
  localparam int WCNT_W    = ssc_pkg::WCNT_W;
  localparam int ROW_W     = ssc_pkg::ROW_W;
  localparam int POS_W     = FRAC_BITS + POS_INT_W;

  localparam logic [STEP_W-1:0]   MIN_STEP = STEP_W'(1) << (FRAC_BITS - 6);
  localparam logic [HEIGHT_W-1:0] MAX_H    = HEIGHT_W'(MAX_OUT_HEIGHT);
  localparam logic [WCNT_W-1:0]   MAX_W    = WCNT_W'(ssc_pkg::MAX_WRITES);

  logic [STEP_W-1:0]   step_q;
  logic [HEIGHT_W-1:0] height_q;
  logic [BYTE_W-1:0]   byte_q, top_q, len_q, idx_q;
  logic [POS_W-1:0]    src_q;
  logic [ORCNT_W-1:0]  row_q;
  logic [WCNT_W-1:0]   cnt_q;
  logic                out_valid_q;
  ssc_pkg::out_word_t  out_q;

  logic [STEP_W-1:0]    eff_step;
  logic [HEIGHT_W-1:0]  eff_height;
  logic [POS_W-1:0]     src_next;
  logic [POS_INT_W-1:0] src_int, src_next_int;
  logic [BYTE_W:0]      want;
  logic [ORCNT_W:0]     row_inc;
  logic [ORCNT_W-1:0]   row_sat;
  logic [WCNT_W:0]      cnt_inc;
  logic [BYTE_W-1:0]    idx_next;
  logic                 more;

  assign eff_step     = (step_q < MIN_STEP) ? MIN_STEP : step_q;
  assign eff_height   = (height_q > MAX_H) ? MAX_H : height_q;
  assign src_next     = src_q + POS_W'(eff_step);
  assign src_int      = src_q[POS_W-1:FRAC_BITS];
  assign src_next_int = src_next[POS_W-1:FRAC_BITS];
  assign want         = {1'b0, top_q} + {1'b0, idx_q};
  assign row_inc      = {1'b0, row_q} + (ORCNT_W+1)'(1);
  assign row_sat      = row_inc[ORCNT_W] ? row_q : row_inc[ORCNT_W-1:0];
  assign cnt_inc      = {1'b0, cnt_q} + (WCNT_W+1)'(1);
  assign idx_next     = idx_q + BYTE_W'(1);

  // does the row after this write hit the same byte again
  assign more = (cnt_inc < (WCNT_W+1)'(MAX_W))
             && (src_next_int == POS_INT_W'(want))
             && (row_inc < (ORCNT_W+1)'(eff_height));

  always_comb begin
    status_o           = '0;
    status_o.end_mark  = (byte_q == ssc_pkg::END_MARK);
    status_o.len_zero  = (len_q == '0);
    status_o.skip_need = (src_int < POS_INT_W'(top_q));
    status_o.hit       = (cnt_q < MAX_W)
                      && (src_int == POS_INT_W'(want))
                      && (row_q < ORCNT_W'(eff_height));
    status_o.idx_done  = (idx_next >= len_q);
    status_o.out_free  = !out_valid_q || !out_stall_i;
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= ssc_pkg::RESET_ROW_STEP;
      height_q <= ssc_pkg::RESET_OUT_HEIGHT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ssc_pkg::REG_ROW_STEP:   step_q   <= cfg_wdata_i[STEP_W-1:0];
        ssc_pkg::REG_OUT_HEIGHT: height_q <= cfg_wdata_i[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // column state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q <= '0;
      row_q <= '0;
      top_q <= '0;
      len_q <= '0;
      idx_q <= '0;
      cnt_q <= '0;
    end else begin
      if (cmd_i.col_reset) begin
        src_q <= '0;
        row_q <= '0;
        top_q <= '0;
        len_q <= '0;
        idx_q <= '0;
      end else begin
        if (cmd_i.step) begin
          src_q <= src_next;
          row_q <= row_sat;
        end
        if (cmd_i.load_top) top_q <= byte_q;
        if (cmd_i.load_len) len_q <= byte_q;
        if (cmd_i.clr_idx) begin
          idx_q <= '0;
        end else if (cmd_i.idx_inc) begin
          idx_q <= idx_next;
        end
      end
      if (cmd_i.clr_cnt) begin
        cnt_q <= '0;
      end else if (cmd_i.emit_pix) begin
        cnt_q <= cnt_inc[WCNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_byte) byte_q <= column_byte_i;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_pix || cmd_i.emit_mark) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_pix) begin
      out_q.kind  <= ssc_pkg::KIND_PIXEL;
      out_q.row   <= row_q[ROW_W-1:0];
      out_q.pixel <= byte_q;
      out_q.last  <= !more;
    end else if (cmd_i.emit_mark) begin
      out_q.kind  <= ssc_pkg::KIND_MARK;
      out_q.row   <= '0;
      out_q.pixel <= '0;
      out_q.last  <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

>>> sv/scaled_sprite_column_decoder.sv
// ----------------------------------------------------------------------------
// scaled_sprite_column_decoder
// Turns a sprite column post stream into scaled per-row pixel writes.
// ----------------------------------------------------------------------------
// Use:
//   in channel  : one column byte per word (in_valid_i / in_stall_o), with
//                 column_start set on the first byte of a new column.
//   out channel : pixel writes and end-of-column markers (out_valid_o /
//                 out_stall_i); last marks the final word caused by a byte.
//   cfg port    : cfg_we_i writes row_step (index 0) or out_height (index 1);
//                 write only while the block is idle.
// Sequence: one byte is worked at a time; length, pad and tail bytes are
//   simply dispatched. A top-row byte steps the position once per output row
//   skipped before the post. A data byte makes one pixel write per output row
//   on it (up to 64); an end mark waits for a free output register. The
//   position stepper adds row_step once per cycle, held while a write stalls.
// Results sit in a single output register; a stalled receiver holds the
//   word and pauses further writes and markers until it is taken, and a new
//   byte is taken while a finished word still waits.
// Reset: async, active low; row_step = 1.0, out_height = 200, column state
//   cleared, output empty.
// ----------------------------------------------------------------------------
module scaled_sprite_column_decoder #(
  parameter int FRAC_BITS      = ssc_pkg::FRAC_BITS,
  parameter int MAX_OUT_HEIGHT = ssc_pkg::MAX_OUT_HEIGHT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  ssc_pkg::in_word_t               in_word_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output ssc_pkg::out_word_t              out_word_o,
  input  logic                            cfg_we_i,
  input  logic [ssc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ssc_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  ssc_pkg::ctrl_cmd_t    cmd;
  ssc_pkg::ctrl_status_t status;

  // sequencer: parse phase, skip loop, write loop, marker
  ssc_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .column_start_i (in_word_i.column_start),
    .in_stall_o     (in_stall_o),
    .status_i       (status),
    .cmd_o          (cmd)
  );

  // position / row counters, post fields, config, output register
  ssc_datapath #(
    .FRAC_BITS      (FRAC_BITS),
    .MAX_OUT_HEIGHT (MAX_OUT_HEIGHT)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .column_byte_i (in_word_i.column_byte),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_word_o    (out_word_o)
  );

endmodule

>>> sv/ssc_checker.sv
// ----------------------------------------------------------------------------
// ssc_checker
// Port-level checks of the scaled sprite column decoder, bound to the top.
// ----------------------------------------------------------------------------
`include "scaled_sprite_column_decoder_macros.svh"

module ssc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input ssc_pkg::out_word_t out_word_o
);

  logic in_take, out_wait, mark_seen, mark_clean;

  assign in_take    = in_valid_i && !in_stall_o;
  assign out_wait   = out_valid_o && out_stall_i;
  assign mark_seen  = out_valid_o && (out_word_o.kind == ssc_pkg::KIND_MARK);
  assign mark_clean = (out_word_o.row == '0) && (out_word_o.pixel == '0)
                   && out_word_o.last;

  // a stalled word stays put
  `SSC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_wait, out_valid_o && $stable(out_word_o))

  // markers carry no pixel and close their byte
  `SSC_ASSERT_IMP(a_marker_form, clk_i, rst_ni, mark_seen, mark_clean)

  // one byte in flight: the block is busy right after taking a word
  `SSC_ASSERT_NXT(a_one_byte, clk_i, rst_ni, in_take, in_stall_o)

endmodule

bind scaled_sprite_column_decoder ssc_checker u_ssc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
